// ===== src/ahse_pkg.sv =====
// Shared constants, types and helpers for the ASCII hex string encoder.
package ahse_pkg;

  localparam int HEX_DIGITS_PER_LINE = 76;
  localparam int SPLIT_LIMIT         = 64000;
  localparam int BYTES_PER_CHUNK     = (HEX_DIGITS_PER_LINE + 1) / 2;
  localparam int MAX_CHARS           = 12;

  localparam logic [6:0] CH_LT   = 7'h3c;
  localparam logic [6:0] CH_GT   = 7'h3e;
  localparam logic [6:0] CH_NL   = 7'h0a;
  localparam logic [6:0] CH_ZERO = 7'h30;

  localparam logic [5:0]  CHUNK_BYTES = 6'(BYTES_PER_CHUNK);
  localparam logic [15:0] SPLIT_BYTES = 16'(SPLIT_LIMIT);

  // All characters that one input word produces, first one at index 0.
  typedef struct packed {
    logic [MAX_CHARS-1:0][6:0] chars;
    logic [3:0]                cnt;
  } plan_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] ext;
    ext = {3'b000, nib};
    if (nib < 4'd10) begin
      return CH_ZERO + ext;
    end else begin
      return 7'h57 + ext;
    end
  endfunction

endpackage

// ===== src/ahse_plan.sv =====
// Input register stage: tracks chunk and split counts and builds the character list.
module ahse_plan (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              block_end,
  output logic              plan_valid,
  input  logic              plan_take,
  output ahse_pkg::plan_t   plan
);
  import ahse_pkg::*;

  logic [5:0]  line_bytes, line_bytes_next;
  logic [15:0] split_bytes, split_bytes_next;
  logic        in_block, in_block_next;
  logic [5:0]  lb_inc;
  logic [15:0] sb_inc;
  logic        chunk_end, do_split, do_newline;
  logic [3:0]  n;
  plan_t       plan_next;
  logic        accept;

  assign in_ready = !plan_valid || plan_take;
  assign accept   = in_valid && in_ready;

  always_comb begin
    lb_inc     = line_bytes + 6'd1;
    sb_inc     = (split_bytes == 16'hffff) ? split_bytes : split_bytes + 16'd1;
    chunk_end  = (lb_inc >= CHUNK_BYTES) || block_end;
    do_split   = chunk_end && (sb_inc >= SPLIT_BYTES);
    do_newline = chunk_end && !do_split && !block_end;

    if (block_end) begin
      line_bytes_next  = '0;
      split_bytes_next = '0;
      in_block_next    = 1'b0;
    end else begin
      line_bytes_next  = chunk_end ? 6'd0 : lb_inc;
      split_bytes_next = do_split ? 16'd0 : sb_inc;
      in_block_next    = 1'b1;
    end
  end

  // Characters are appended in text order; n points at the next free slot.
  always_comb begin
    plan_next = '0;
    n         = '0;
    if (!in_block) begin
      plan_next.chars[n] = CH_LT;
      n = n + 4'd1;
    end
    plan_next.chars[n]         = hex_char(data_byte[7:4]);
    plan_next.chars[n + 4'd1]  = hex_char(data_byte[3:0]);
    n = n + 4'd2;
    if (do_split) begin
      plan_next.chars[n]         = CH_ZERO;
      plan_next.chars[n + 4'd1]  = CH_ZERO;
      plan_next.chars[n + 4'd2]  = CH_GT;
      plan_next.chars[n + 4'd3]  = CH_NL;
      plan_next.chars[n + 4'd4]  = CH_LT;
      n = n + 4'd5;
    end else if (do_newline) begin
      plan_next.chars[n] = CH_NL;
      n = n + 4'd1;
    end
    if (block_end) begin
      plan_next.chars[n]         = CH_ZERO;
      plan_next.chars[n + 4'd1]  = CH_ZERO;
      plan_next.chars[n + 4'd2]  = CH_GT;
      plan_next.chars[n + 4'd3]  = CH_NL;
      n = n + 4'd4;
    end
    plan_next.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_bytes  <= '0;
      split_bytes <= '0;
      in_block    <= 1'b0;
      plan_valid  <= 1'b0;
    end else begin
      if (accept) begin
        line_bytes  <= line_bytes_next;
        split_bytes <= split_bytes_next;
        in_block    <= in_block_next;
      end
      if (in_ready) begin
        plan_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      plan <= plan_next;
    end
  end

  a_closed_block_clear: assert property (@(posedge clk) disable iff (rst)
    !in_block |-> (line_bytes == 6'd0) && (split_bytes == 16'd0))
    else $error("counts not cleared outside a block");

  a_chunk_bound: assert property (@(posedge clk) disable iff (rst)
    line_bytes < CHUNK_BYTES)
    else $error("chunk count reached chunk length");

  a_plan_count: assert property (@(posedge clk) disable iff (rst)
    plan_valid |-> (plan.cnt >= 4'd2) && (plan.cnt <= 4'(MAX_CHARS)))
    else $error("character count out of range");

endmodule

// ===== src/ahse_emit.sv =====
// Output stage: walks the buffered character list one character per cycle while out_ready allows it.
module ahse_emit (
  input  logic              clk,
  input  logic              rst,
  input  logic              plan_valid,
  output logic              plan_take,
  input  ahse_pkg::plan_t   plan,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [6:0]        out_char,
  output logic              run_last
);
  import ahse_pkg::*;

  plan_t      cur;
  logic       cur_valid;
  logic [3:0] step;
  logic       out_free, emit, at_end, cur_done;

  assign out_free  = !out_valid || out_ready;
  assign emit      = cur_valid && out_free;
  assign at_end    = (step == cur.cnt - 4'd1);
  assign cur_done  = emit && at_end;
  assign plan_take = plan_valid && (!cur_valid || cur_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (plan_take) begin
        cur_valid <= 1'b1;
        step      <= '0;
      end else if (cur_done) begin
        cur_valid <= 1'b0;
        step      <= '0;
      end else if (emit) begin
        step <= step + 4'd1;
      end
      if (out_free) begin
        out_valid <= cur_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (plan_take) begin
      cur <= plan;
    end
    if (emit) begin
      out_char <= cur.chars[step];
      run_last <= at_end;
    end
  end

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (step < cur.cnt))
    else $error("step ran past the character count");

  a_take_only_when_free: assert property (@(posedge clk) disable iff (rst)
    plan_take |-> (!cur_valid || cur_done))
    else $error("new word loaded over one still being sent");

  a_step_restart: assert property (@(posedge clk) disable iff (rst)
    plan_take |=> (step == 4'd0) && cur_valid)
    else $error("step not restarted on load");

endmodule

// ===== src/ascii_hex_string_encoder.sv =====
// Top level of the ASCII hex string encoder.
//
// Slave stream: one raw byte per word in s_tdata, s_tlast marks the last
// byte of a block. Master stream: one ASCII character per word in
// m_tdata[6:0], m_tlast marks the last character produced by one input word.
// The text is the hex string form: '<' opens a block, each byte gives two
// lower-case hex digits, a newline ends each chunk of 38 bytes, a split
// inserts "00>\n<" at the first chunk end once 64000 bytes are counted, and
// "00>\n" closes the block. An input word is held in an input register,
// copied to a sequencing register, and each character leaves through an
// output register. The output carries one character per cycle while m_tready
// is high; a word gives two characters normally, three at a chunk end and up
// to eleven at a split that also closes the block, and the next word is
// taken while the current one is still being sent. Reset clears the
// counters, closes any open block and drops all valid flags. When m_tready
// is low, the output register holds and the stages behind it fill, then
// s_tready drops.
module ascii_hex_string_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // block_end
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
  output logic       m_tlast    // run_last
);
  import ahse_pkg::*;

  plan_t      plan;
  logic       plan_valid;
  logic       plan_take;
  logic [6:0] out_char;

  ahse_plan u_plan (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .data_byte  (s_tdata),
    .block_end  (s_tlast),
    .plan_valid (plan_valid),
    .plan_take  (plan_take),
    .plan       (plan)
  );

  ahse_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .plan_valid (plan_valid),
    .plan_take  (plan_take),
    .plan       (plan),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_char   (out_char),
    .run_last   (m_tlast)
  );

  assign m_tdata = {1'b0, out_char};

endmodule
